>>> src/arm32pd_pkg.sv
// ----------------------------------------------------------------------------
// arm32pd_pkg
// Pattern table and field extraction helpers for the ARM32 pattern decoder.
// ----------------------------------------------------------------------------
package arm32pd_pkg;

  localparam int PatCount = 141;
  localparam int SelW     = PatCount;

  // One 32-character pattern per entry; byte b (from the LSB) stands for
  // opcode bit b. '0'/'1' are fixed bits, letters name fields.
  localparam logic [255:0] PAT_TABLE [0:PatCount-1] = '{
    "cccc00I0101Sssssdddd<<<<<<<<<<<<",
    "cccc00I0100Sssssdddd<<<<<<<<<<<<",
    "cccc00I0000Sssssdddd<<<<<<<<<<<<",
    "cccc101Loooooooooooooooooooooooo",
    "cccc00I1110Sssssdddd<<<<<<<<<<<<",
    "111000010010iiiiiiiiiiii0111iiii",
    "1111101Hoooooooooooooooooooooooo",
    "cccc000100101111111111110011dddd",
    "cccc000100101111111111110001dddd",
    "cccc000101101111dddd11110001ssss",
    "cccc00I10111ssss0000<<<<<<<<<<<<",
    "cccc00I10101ssss0000<<<<<<<<<<<<",
    "cccc00I0001Sssssdddd<<<<<<<<<<<<",
    "1111110PUNW1TTTTVVVVxxxxOOOOOOOO",
    "cccc110PUNW1TTTTVVVVxxxxOOOOOOOO",
    "cccc100PU0W1ssssRRRRRRRRRRRRRRRR",
    "cccc100PU101ssss0RRRRRRRRRRRRRRR",
    "cccc01IPU0W1ssssddddaaaaaaaaaaaa",
    "cccc01IPU1W1ssssddddaaaaaaaaaaaa",
    "cccc01I0U111ssssddddaaaaaaaaaaaa",
    "cccc000PUIW1ssssddddaaaa1011aaaa",
    "cccc000PUIW1ssssddddaaaa1101aaaa",
    "cccc000PUIW1ssssddddaaaa1111aaaa",
    "cccc01I0U011ssssddddaaaaaaaaaaaa",
    "cccc0000001Sddddnnnnssss1001mmmm",
    "cccc00I1101S0000dddd<<<<<<<<<<<<",
    "11111110fff1ttttddddxxxxFFF1yyyy",
    "cccc1110fff1ttttddddxxxxFFF1yyyy",
    "cccc00010R000000dddd000000000000",
    "cccc00110R10bbbb1111iiiiiiiiiiii",
    "cccc00010R10bbbb111100000000mmmm",
    "cccc0000000Sdddd0000ssss1001mmmm",
    "cccc00I1111S0000dddd<<<<<<<<<<<<",
    "cccc00I1100Sssssdddd<<<<<<<<<<<<",
    "cccc00I0011Sssssdddd<<<<<<<<<<<<",
    "cccc00I0111Sssssdddd<<<<<<<<<<<<",
    "cccc00I0110Sssssdddd<<<<<<<<<<<<",
    "cccc0000111SDDDDddddssss1001mmmm",
    "cccc0000110SDDDDddddssss1001mmmm",
    "1111110PUNW0ssssTTTTxxxxiiiiiiii",
    "cccc110PUNW0ssssTTTTxxxxiiiiiiii",
    "cccc100PU0W0ssssRRRRRRRRRRRRRRRR",
    "cccc100PU100ssssRRRRRRRRRRRRRRRR",
    "cccc01IPU0W0ssssddddaaaaaaaaaaaa",
    "cccc01IPU1W0ssssddddaaaaaaaaaaaa",
    "cccc01I0U110ssssddddaaaaaaaaaaaa",
    "cccc000PUIW0ssssddddaaaa1011aaaa",
    "cccc01I0U010ssssddddaaaaaaaaaaaa",
    "cccc00I0010Sssssdddd<<<<<<<<<<<<",
    "cccc1111iiiiiiiiiiiiiiiiiiiiiiii",
    "cccc00010000ssssdddd00001001mmmm",
    "cccc00010100ssssdddd00001001mmmm",
    "cccc00I10011ssss0000<<<<<<<<<<<<",
    "cccc00I10001ssss0000<<<<<<<<<<<<",
    "cccc0000101SDDDDddddssss1001mmmm",
    "cccc0000100SDDDDddddssss1001mmmm",
    "cccc000PUIW0ssssddddaaaa1101aaaa",
    "cccc11000100nnnnddddxxxxFFFFyyyy",
    "cccc11000101nnnnddddxxxxFFFFyyyy",
    "111101I1U101ssss1111aaaaaaaaaaaa",
    "cccc00010000ssssdddd00000101mmmm",
    "cccc00010100ssssdddd00000101mmmm",
    "cccc00010110ssssdddd00000101mmmm",
    "cccc00010010ssssdddd00000101mmmm",
    "cccc00010000ddddnnnnssss1YX0mmmm",
    "cccc00010100DDDDddddssss1YX0mmmm",
    "cccc00010010ddddnnnnssss1Y00mmmm",
    "cccc00010110dddd0000ssss1YX0mmmm",
    "cccc00010010dddd0000ssss1Y10mmmm",
    "cccc000PUIW0nnnnddddaaaa1111aaaa",
    "11111110ffffTTTTttttxxxxFFF0yyyy",
    "cccc1110ffffTTTTttttxxxxFFF0yyyy",
    "cccc111010110000VVVV10111100TTTT",
    "cccc11101v110000VVVV101111t0TTTT",
    "cccc11100011TTTTVVVV10110000ZZZZ",
    "cccc11100T11TTTTVVVV1010t0z0ZZZZ",
    "cccc111010110100TTTT10110100ZZZZ",
    "cccc111010110100TTTT10111100ZZZZ",
    "cccc11101t110100TTTT101011z0ZZZZ",
    "cccc111010110101TTTT101111000000",
    "cccc11101t110101TTTT101111000000",
    "cccc11101t110100TTTT101001z0ZZZZ",
    "cccc111010110101TTTT101101000000",
    "cccc11101t110101TTTT101001000000",
    "cccc111010110000VVVV10110100TTTT",
    "cccc11101v110000VVVV101001t0TTTT",
    "cccc111010110111VVVV101011t0TTTT",
    "cccc11101v110111VVVV10111100TTTT",
    "cccc11101000TTTTVVVV10110000ZZZZ",
    "cccc11101t00TTTTVVVV1010v0z0ZZZZ",
    "cccc1101U001ssssVVVV1011OOOOOOOO",
    "cccc110PU0W1ssssVVVV1011OOOOOOOO",
    "cccc110PUvW1ssssVVVV1010OOOOOOOO",
    "cccc110PU0W1ssssVVVV1011OOOOOOOO",
    "cccc1101Uv01ssssVVVV1010OOOOOOOO",
    "cccc11100000TTTTVVVV10110000ZZZZ",
    "cccc11100v00TTTTVVVV1010t0z0ZZZZ",
    "cccc11100010VVVVssss101100010000",
    "cccc11100000VVVVssss101100010000",
    "cccc11100011TTTTdddd101100010000",
    "cccc11100001TTTTdddd101100010000",
    "cccc11100001TTTTdddd1010t0010000",
    "cccc11101111QQQQdddd101000010000",
    "cccc11100001TTTTVVVV10110000ZZZZ",
    "cccc11100v01TTTTVVVV1010t0z0ZZZZ",
    "cccc11100000TTTTdddd1010t0010000",
    "cccc1110111100011111101000010000",
    "cccc11100010TTTTVVVV10110000ZZZZ",
    "cccc11100v10TTTTVVVV1010t0z0ZZZZ",
    "cccc11101110QQQQssss101000010000",
    "cccc111010110001VVVV10110100TTTT",
    "cccc11101v110001VVVV10100t00TTTT",
    "cccc11100000TTTTVVVV10110100ZZZZ",
    "cccc11100v00TTTTVVVV1010t1z0ZZZZ",
    "cccc11100001TTTTVVVV10110100ZZZZ",
    "cccc11100v01TTTTVVVV1010t1z0ZZZZ",
    "cccc11100010TTTTVVVV10110100ZZZZ",
    "cccc11100v10TTTTVVVV1010t1z0ZZZZ",
    "cccc111010111000VVVV101111t0TTTT",
    "cccc11101v111000VVVV101011t0TTTT",
    "cccc111010110001VVVV10111100TTTT",
    "cccc11101v110001VVVV101011t0TTTT",
    "cccc1101U000ssssVVVV1011OOOOOOOO",
    "cccc110PU0W0ssssVVVV1011OOOOOOOO",
    "cccc110PUvW0ssssVVVV1010OOOOOOOO",
    "cccc110PU0W0ssssVVVV1011OOOOOOOO",
    "cccc1101Uv00ssssVVVV1010OOOOOOOO",
    "cccc11100011TTTTVVVV10110100ZZZZ",
    "cccc11100v11TTTTVVVV1010t1z0ZZZZ",
    "cccc11101v111101VVVV10110100TTTT",
    "cccc11101v111101VVVV10111100TTTT",
    "cccc11101v111101VVVV101001t0TTTT",
    "cccc11101v111101VVVV101011t0TTTT",
    "cccc11101v111100VVVV10110100TTTT",
    "cccc11101v111100VVVV10111100TTTT",
    "cccc11101v111100VVVV101001t0TTTT",
    "cccc11101v111100VVVV101011t0TTTT",
    "cccc111010111000VVVV101101t0TTTT",
    "cccc11101v111000VVVV101001t0TTTT",
    "11111110fff0TTTTssssxxxxFFF1yyyy",
    "cccc1110fff0TTTTssssxxxxFFF1yyyy"
  };

  // Registered match result handed from the matcher to the extractor
  typedef struct packed {
    logic              valid;
    logic [SelW-1:0]   sel;
    logic [31:0]       word;
    logic [31:0]       addr;
  } match_t;

  // Positions where the pattern has a fixed bit
  function automatic logic [31:0] pat_mask(input int k);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      m[b] = (PAT_TABLE[k][8*b +: 8] == "0") || (PAT_TABLE[k][8*b +: 8] == "1");
    end
    return m;
  endfunction

  function automatic logic [31:0] pat_value(input int k);
    logic [31:0] v;
    v = '0;
    for (int b = 0; b < 32; b++) begin
      v[b] = (PAT_TABLE[k][8*b +: 8] == "1");
    end
    return v;
  endfunction

  function automatic logic [31:0] field_mask(input int k, input logic [7:0] ch);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      m[b] = (PAT_TABLE[k][8*b +: 8] == ch);
    end
    return m;
  endfunction

  function automatic logic [4:0] field_low(input int k, input logic [7:0] ch);
    logic [4:0] lo;
    lo = '0;
    for (int b = 31; b >= 0; b--) begin
      if (PAT_TABLE[k][8*b +: 8] == ch) lo = 5'(b);
    end
    return lo;
  endfunction

  function automatic logic has_field(input int k, input logic [7:0] ch);
    return |field_mask(k, ch);
  endfunction

  // Field bits kept in place, shifted down to the lowest position
  function automatic logic [31:0] grab(input int k, input logic [7:0] ch,
                                       input logic [31:0] word);
    return (word & field_mask(k, ch)) >> field_low(k, ch);
  endfunction

endpackage

>>> src/arm32pd_match.sv
// ----------------------------------------------------------------------------
// arm32pd_match
// Input register and first-match search across the pattern table.
// ----------------------------------------------------------------------------
module arm32pd_match (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         opcode,
  input  logic [31:0]         instr_address,
  output arm32pd_pkg::match_t match_q
);
  import arm32pd_pkg::*;

  logic        in_valid;
  logic [31:0] in_word;
  logic [31:0] in_addr;
  logic [SelW-1:0] sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    in_word <= opcode;
    in_addr <= instr_address;
  end

  // One-hot of the first hitting entry
  always_comb begin
    logic found;
    found    = 1'b0;
    sel_next = '0;
    for (int k = 0; k < PatCount; k++) begin
      if (!found && ((in_word & pat_mask(k)) == pat_value(k))) begin
        sel_next[k] = 1'b1;
        found       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q.valid <= 1'b0;
    end else begin
      match_q.valid <= in_valid;
    end
    match_q.sel  <= sel_next;
    match_q.word <= in_word;
    match_q.addr <= in_addr;
  end

endmodule

>>> src/arm32pd_extract.sv
// ----------------------------------------------------------------------------
// arm32pd_extract
// Field extraction for the selected entry, branch target add, result register.
// ----------------------------------------------------------------------------
module arm32pd_extract (
  input  logic                clk,
  input  logic                rst,
  input  arm32pd_pkg::match_t match_q,
  output logic                done,
  output logic                matched,
  output logic [7:0]          entry_index,
  output logic [3:0]          cond_code,
  output logic [2:0]          suffix_flags,
  output logic [15:0]         core_regs,
  output logic [14:0]         fp_regs,
  output logic [15:0]         coproc_fields,
  output logic [15:0]         reg_list,
  output logic [23:0]         immediate,
  output logic [25:0]         branch_offset,
  output logic [31:0]         branch_target
);
  import arm32pd_pkg::*;

  logic        matched_next;
  logic [7:0]  index_next;
  logic [3:0]  cond_next;
  logic [2:0]  suffix_next;
  logic [15:0] core_next;
  logic [14:0] fp_next;
  logic [15:0] coproc_next;
  logic [15:0] reglist_next;
  logic [23:0] imm_next;
  logic [25:0] offset_next;
  logic        has_o;
  logic [31:0] target_next;

  // AND-OR select over the one-hot; every entry's extraction is fixed wiring
  always_comb begin
    logic [31:0] w;
    w            = match_q.word;
    matched_next = |match_q.sel;
    index_next   = '0;
    cond_next    = '0;
    suffix_next  = '0;
    core_next    = '0;
    fp_next      = '0;
    coproc_next  = '0;
    reglist_next = '0;
    imm_next     = '0;
    offset_next  = '0;
    has_o        = 1'b0;
    for (int k = 0; k < PatCount; k++) begin
      if (match_q.sel[k]) begin
        index_next   |= 8'(k);
        cond_next    |= 4'(grab(k, "c", w));
        suffix_next  |= {1'(grab(k, "Y", w)), 1'(grab(k, "X", w)), 1'(grab(k, "L", w))};
        core_next    |= {4'(grab(k, "D", w)), 4'(grab(k, "d", w)),
                         4'(grab(k, "s", w)), 4'(grab(k, "m", w))};
        if (has_field(k, "V")) fp_next[14:10] |= {4'(grab(k, "V", w)), 1'(grab(k, "v", w))};
        if (has_field(k, "T")) fp_next[9:5]   |= {4'(grab(k, "T", w)), 1'(grab(k, "t", w))};
        if (has_field(k, "Z")) fp_next[4:0]   |= {4'(grab(k, "Z", w)), 1'(grab(k, "z", w))};
        coproc_next  |= {4'(grab(k, "x", w)), 4'(grab(k, "f", w)),
                         4'(grab(k, "F", w)), 4'(grab(k, "Q", w))};
        reglist_next |= 16'(grab(k, "R", w));
        imm_next     |= 24'(grab(k, "i", w));
        if (has_field(k, "o")) begin
          has_o       = 1'b1;
          offset_next |= {24'(grab(k, "o", w)), 1'(grab(k, "H", w)), 1'b0};
        end
      end
    end
    target_next = has_o ? (match_q.addr + {6'b0, offset_next}) : 32'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= match_q.valid;
    end
    matched       <= matched_next;
    entry_index   <= index_next;
    cond_code     <= cond_next;
    suffix_flags  <= suffix_next;
    core_regs     <= core_next;
    fp_regs       <= fp_next;
    coproc_fields <= coproc_next;
    reg_list      <= reglist_next;
    immediate     <= imm_next;
    branch_offset <= offset_next;
    branch_target <= target_next;
  end

`ifndef ASSERT_OFF
  a_sel_onehot0: assert property (@(posedge clk) disable iff (rst)
    match_q.valid |-> $onehot0(match_q.sel))
    else $error("more than one entry selected");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    match_q.valid |=> done)
    else $error("result strobe missing");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_index < 8'(PatCount)))
    else $error("entry index out of range");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (entry_index == '0 && branch_target == '0 && core_regs == '0))
    else $error("fields not cleared on miss");

  a_target_sum: assert property (@(posedge clk) disable iff (rst)
    (done && branch_offset != '0) |->
      (branch_target == $past(match_q.addr) + {6'b0, branch_offset}))
    else $error("branch target mismatch");
`endif

endmodule

>>> src/arm32_pattern_decoder_core.sv
// ----------------------------------------------------------------------------
// arm32_pattern_decoder_core
// ARM32 instruction decoder against a fixed table of bit patterns.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy is always low.
// Each request yields exactly one result, strobed by done for one cycle;
// the request passes in order through an input register, a registered
// first-match search over the 141 patterns, then field extraction and
// the branch target add into the result register. Results cannot be
// held off.
module arm32_pattern_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] opcode,
  input  logic [31:0] instr_address,
  output logic        done,
  output logic        matched,
  output logic [7:0]  entry_index,
  output logic [3:0]  cond_code,
  output logic [2:0]  suffix_flags,
  output logic [15:0] core_regs,
  output logic [14:0] fp_regs,
  output logic [15:0] coproc_fields,
  output logic [15:0] reg_list,
  output logic [23:0] immediate,
  output logic [25:0] branch_offset,
  output logic [31:0] branch_target
);
  import arm32pd_pkg::*;

  match_t match_q;

  assign busy = 1'b0;

  arm32pd_match u_match (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .opcode        (opcode),
    .instr_address (instr_address),
    .match_q       (match_q)
  );

  arm32pd_extract u_extract (
    .clk           (clk),
    .rst           (rst),
    .match_q       (match_q),
    .done          (done),
    .matched       (matched),
    .entry_index   (entry_index),
    .cond_code     (cond_code),
    .suffix_flags  (suffix_flags),
    .core_regs     (core_regs),
    .fp_regs       (fp_regs),
    .coproc_fields (coproc_fields),
    .reg_list      (reg_list),
    .immediate     (immediate),
    .branch_offset (branch_offset),
    .branch_target (branch_target)
  );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ARM32 pattern decoder core.
// Words aimed at every table entry, the all-zero and all-one extremes,
// and random words and addresses are sent with random idle bursts. A local
// first-match decoder predicts each result. A checker process compares
// each strobed result with the oldest prediction as one packed value.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arm32pd_pkg::*;

  typedef struct packed {
    logic        matched;
    logic [7:0]  entry_index;
    logic [3:0]  cond_code;
    logic [2:0]  suffix_flags;
    logic [15:0] core_regs;
    logic [14:0] fp_regs;
    logic [15:0] coproc_fields;
    logic [15:0] reg_list;
    logic [23:0] immediate;
    logic [25:0] branch_offset;
    logic [31:0] branch_target;
  } decode_t;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] opcode;
  logic [31:0] instr_address;
  logic        done;
  decode_t     got;

  decode_t     pending_decodes[$];
  int          errors;
  int          cycles;
  int          sent;
  int          checked;
  int          hit_count;
  bit          idle_on;

  arm32_pattern_decoder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .instr_address (instr_address),
    .done          (done),
    .matched       (got.matched),
    .entry_index   (got.entry_index),
    .cond_code     (got.cond_code),
    .suffix_flags  (got.suffix_flags),
    .core_regs     (got.core_regs),
    .fp_regs       (got.fp_regs),
    .coproc_fields (got.coproc_fields),
    .reg_list      (got.reg_list),
    .immediate     (got.immediate),
    .branch_offset (got.branch_offset),
    .branch_target (got.branch_target)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [7:0] pat_char(int k, int b);
    return PAT_TABLE[k][8*b +: 8];
  endfunction

  // Fixed-bit care mask and value of one entry
  function automatic logic [63:0] fixed_bits(int k);
    logic [31:0] care;
    logic [31:0] val;
    care = '0;
    val  = '0;
    for (int b = 0; b < 32; b++) begin
      care[b] = (pat_char(k, b) == "0") || (pat_char(k, b) == "1");
      val[b]  = (pat_char(k, b) == "1");
    end
    return {care, val};
  endfunction

  // Bits of one letter kept in place and moved down to its lowest position
  function automatic logic [31:0] field_of(int k, logic [7:0] ch, logic [31:0] w,
                                           output bit present);
    logic [31:0] acc;
    int          lo;
    acc = '0;
    lo = 0;
    present = 0;
    for (int b = 31; b >= 0; b--) begin
      if (pat_char(k, b) == ch) begin
        acc[b] = w[b];
        lo = b;
        present = 1;
      end
    end
    return acc >> lo;
  endfunction

  function automatic logic [31:0] fld(int k, logic [7:0] ch, logic [31:0] w);
    bit p;
    return field_of(k, ch, w, p);
  endfunction

  function automatic logic [4:0] vfp_reg(int k, logic [7:0] hi, logic [7:0] lo,
                                         logic [31:0] w);
    bit          p;
    logic [31:0] top;
    logic [5:0]  idx;
    top = field_of(k, hi, w, p);
    if (!p) return 5'd0;
    idx = {top[4:0], 1'(fld(k, lo, w))};
    return idx[4:0];
  endfunction

  function automatic decode_t decode_word(logic [31:0] w, logic [31:0] addr);
    decode_t     r;
    logic [63:0] fb;
    logic [31:0] o;
    logic [25:0] off;
    bit          has_o;
    int          k;
    r = '0;
    k = -1;
    for (int j = 0; j < PatCount; j++) begin
      fb = fixed_bits(j);
      if ((w & fb[63:32]) == fb[31:0]) begin
        k = j;
        break;
      end
    end
    if (k < 0) return r;
    r.matched       = 1'b1;
    r.entry_index   = 8'(k);
    r.cond_code     = 4'(fld(k, "c", w));
    r.suffix_flags  = {1'(fld(k, "Y", w)), 1'(fld(k, "X", w)), 1'(fld(k, "L", w))};
    r.core_regs     = {4'(fld(k, "D", w)), 4'(fld(k, "d", w)),
                       4'(fld(k, "s", w)), 4'(fld(k, "m", w))};
    r.fp_regs       = {vfp_reg(k, "V", "v", w), vfp_reg(k, "T", "t", w),
                       vfp_reg(k, "Z", "z", w)};
    r.coproc_fields = {4'(fld(k, "x", w)), 4'(fld(k, "f", w)),
                       4'(fld(k, "F", w)), 4'(fld(k, "Q", w))};
    r.reg_list      = 16'(fld(k, "R", w));
    r.immediate     = 24'(fld(k, "i", w));
    o = field_of(k, "o", w, has_o);
    if (has_o) begin
      off = {o[23:0], 2'b00};
      if ((fld(k, "H", w) & 32'd1) != 32'd0) off = off + 26'd2;
      r.branch_offset = off;
      r.branch_target = addr + 32'(off);
    end
    return r;
  endfunction

  // Random word that satisfies the fixed bits of one entry
  function automatic logic [31:0] word_for(int k);
    logic [63:0] fb;
    fb = fixed_bits(k);
    return ($urandom & ~fb[63:32]) | fb[31:0];
  endfunction

  task automatic idle_gap();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [31:0] w, logic [31:0] addr);
    idle_gap();
    start         <= 1'b1;
    opcode        <= w;
    instr_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_decodes.push_back(decode_word(w, addr));
    sent++;
  endtask

  always @(posedge clk) begin
    decode_t want;
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: result with no request outstanding: %h", $time, got);
        errors++;
      end else begin
        want = pending_decodes.pop_front();
        checked++;
        if (want.matched) hit_count++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          if (got.entry_index !== want.entry_index)
            $display("%0t:   entry_index expected %0d actual %0d", $time,
                     want.entry_index, got.entry_index);
          if (got.fp_regs !== want.fp_regs)
            $display("%0t:   fp_regs expected %h actual %h", $time,
                     want.fp_regs, got.fp_regs);
          if (got.branch_target !== want.branch_target)
            $display("%0t:   branch_target expected %h actual %h", $time,
                     want.branch_target, got.branch_target);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_decodes.size());
      $display("FAIL arm32_pattern_decoder_core");
      $finish;
    end
  end

  task automatic test_extremes();
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hEAFF_FFFF, 32'hFFFF_FFFC);
    send_request(32'hFBFF_FFFF, 32'hFFFF_FFF0);
    send_request(32'hFAFF_FFFF, 32'h0000_0000);
    send_request(32'hE92D_FFFF, 32'h8000_0000);
    send_request(32'hF7FF_FFFF, 32'h1234_5678);
    send_request(32'hE12F_FF1E, 32'h0000_1000);
    send_request(32'hEEB0_0B40, 32'h0000_2000);
    send_request(32'hEEF0_FA40, 32'h0000_2004);
  endtask

  // One word aimed at every table entry
  task automatic test_each_entry();
    for (int k = 0; k < PatCount; k++)
      send_request(word_for(k), $urandom);
  endtask

  task automatic test_random(int count);
    logic [31:0] w;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) w = $urandom;
      else w = word_for($urandom_range(0, PatCount - 1));
      send_request(w, $urandom);
    end
  endtask

  initial begin
    int drain;
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    instr_address = '0;
    errors = 0;
    cycles = 0;
    sent = 0;
    checked = 0;
    hit_count = 0;
    idle_on = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_each_entry();
    test_random(1000);
    // last stretch runs back to back
    idle_on = 1'b0;
    test_random(250);
    start <= 1'b0;
    drain = 0;
    while (pending_decodes.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_decodes.size());
      errors++;
    end
    $display("Sent %0d requests, checked %0d results, %0d matched a table entry",
             sent, checked, hit_count);
    $display("Every entry targeted, plus all-zero/all-one words; %0d errors", errors);
    if (errors == 0) begin
      $display("PASS arm32_pattern_decoder_core");
    end else begin
      $display("FAIL arm32_pattern_decoder_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/arm32pd_pkg.sv
src/arm32pd_match.sv
src/arm32pd_extract.sv
src/arm32_pattern_decoder_core.sv
verif/tb_top.sv
